// ----- hdl/mel_pkg.sv -----
`timescale 1ns / 1ps
package mel_pkg;

    localparam int MUL_W = 28;
    localparam int PRD_W = 2 * MUL_W;
    localparam int PX_W  = 18;

    localparam logic       OP_START = 1'b0;
    localparam logic       OP_STEP  = 1'b1;

    localparam logic       REG_GRID_W = 1'b0;
    localparam logic       REG_GRID_H = 1'b1;

    localparam logic [2:0] SEL_AA  = 3'd0;
    localparam logic [2:0] SEL_BB  = 3'd1;
    localparam logic [2:0] SEL_AB  = 3'd2;
    localparam logic [2:0] SEL_XX  = 3'd3;
    localparam logic [2:0] SEL_BX  = 3'd4;
    localparam logic [2:0] SEL_YY  = 3'd5;
    localparam logic [2:0] SEL_AY  = 3'd6;
    localparam logic [2:0] SEL_AB2 = 3'd7;

    typedef struct packed {
        logic       mul_start;
        logic [2:0] sel;
        logic       load_start;
        logic       init;
        logic       trans;
        logic       load_pts;
        logic       load_mark;
        logic       emit;
        logic       update;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic need_trans;
        logic running;
        logic out_free;
        logic emit_last;
    } t_sts;

endpackage

// ----- hdl/mel_chan_if.sv -----
`timescale 1ns / 1ps
interface mel_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [13:0] center_x;
    logic signed [13:0] center_y;
    logic [11:0]        semi_axis_x;
    logic [11:0]        semi_axis_y;

    modport source (output valid, operation, center_x, center_y, semi_axis_x, semi_axis_y,
                    input ready);
    modport sink (input valid, operation, center_x, center_y, semi_axis_x, semi_axis_y,
                  output ready);
endinterface

interface mel_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] point_x;
    logic [11:0] point_y;
    logic        point_valid;
    logic        last_of_run;
    logic        finished;

    modport source (output valid, point_x, point_y, point_valid, last_of_run, finished,
                    input ready);
    modport sink (input valid, point_x, point_y, point_valid, last_of_run, finished,
                  output ready);
endinterface

// ----- hdl/mel_mul.sv -----
`timescale 1ns / 1ps
module mel_mul
    import mel_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MUL_W-1:0] i_a,
    input  logic [MUL_W-1:0] i_b,
    output logic             o_done,
    output logic [PRD_W-1:0] o_prod
);

    localparam int CNT_W = $clog2(MUL_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [PRD_W-1:0] r_mc;
    logic [MUL_W-1:0] r_mp;
    logic [PRD_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_mc  <= PRD_W'(i_a);
            r_mp  <= i_b;
        end else if (r_busy) begin
            if (r_mp[0]) begin
                r_acc <= r_acc + r_mc;
            end
            r_mc <= r_mc << 1;
            r_mp <= r_mp >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ----- hdl/mel_dp.sv -----
`timescale 1ns / 1ps
module mel_dp
    import mel_pkg::*;
#(
    parameter int MAX_GRID = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [12:0]        i_cfg_data,
    input  logic signed [13:0] i_center_x,
    input  logic signed [13:0] i_center_y,
    input  logic [11:0]        i_semi_axis_x,
    input  logic [11:0]        i_semi_axis_y,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [11:0]        o_point_x,
    output logic [11:0]        o_point_y,
    output logic               o_point_valid,
    output logic               o_last_of_run,
    output logic               o_finished
);

    logic [12:0]        r_grid_w, r_grid_h;
    logic signed [13:0] r_cx, r_cy;
    logic [11:0]        r_a, r_b;
    logic signed [14:0] r_cur_x, r_cur_y, r_prev_x, r_prev_y;
    logic signed [39:0] r_incx, r_incy;
    logic signed [63:0] r_dec;
    logic [23:0]        r_sq_a, r_sq_b;
    logic [PRD_W-1:0]   r_t1, r_t2, r_t3;
    logic               r_r2, r_running, r_fin;
    logic [7:0]         r_mask;
    logic               r_ov;
    logic [11:0]        r_px, r_py;
    logic               r_pv, r_last, r_ofin;

    logic [MUL_W-1:0]   mul_a, mul_b;
    logic               mul_done;
    logic [PRD_W-1:0]   mul_prod;
    logic signed [15:0] ys;
    logic [15:0]        ys_abs;
    logic signed [15:0] dx, dy;
    logic               diag;
    logic signed [PX_W-1:0] lim_w, lim_h;
    logic signed [PX_W-1:0] px [8];
    logic signed [PX_W-1:0] py [8];
    logic signed [14:0] bx, by;
    logic [7:0]         mask;
    logic [2:0]         pick;
    logic [7:0]         rest;
    logic signed [39:0] incx_n, incy_n;
    logic signed [63:0] dec_n;
    logic signed [14:0] cur_x_n, cur_y_n;

    mel_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    assign ys     = 16'(r_cur_y) - 16'sd1;
    assign ys_abs = ys[15] ? 16'(-ys) : 16'(ys);

    always_comb begin
        case (i_cmd.sel)
            SEL_AA:  begin mul_a = MUL_W'(r_a);    mul_b = MUL_W'(r_a); end
            SEL_BB:  begin mul_a = MUL_W'(r_b);    mul_b = MUL_W'(r_b); end
            SEL_AB:  begin mul_a = MUL_W'(r_sq_a); mul_b = MUL_W'(r_b); end
            SEL_XX:  begin
                mul_a = MUL_W'({r_cur_x[13:0], 1'b1});
                mul_b = MUL_W'({r_cur_x[13:0], 1'b1});
            end
            SEL_BX:  begin mul_a = MUL_W'(r_sq_b); mul_b = r_t1[MUL_W-1:0]; end
            SEL_YY:  begin mul_a = MUL_W'(ys_abs); mul_b = MUL_W'(ys_abs); end
            SEL_AY:  begin mul_a = MUL_W'(r_sq_a); mul_b = r_t2[MUL_W-1:0]; end
            SEL_AB2: begin mul_a = MUL_W'(r_sq_a); mul_b = MUL_W'(r_sq_b); end
            default: begin mul_a = '0;             mul_b = '0; end
        endcase
    end

    assign dx   = 16'(r_cur_x) - 16'(r_prev_x);
    assign dy   = 16'(r_cur_y) - 16'(r_prev_y);
    assign diag = (dx == 16'sd1 || dx == -16'sd1) && (dy == 16'sd1 || dy == -16'sd1);

    always_comb begin
        if ({5'b0, r_grid_w} > PX_W'(MAX_GRID)) lim_w = PX_W'(MAX_GRID);
        else lim_w = {5'b0, r_grid_w};
        if ({5'b0, r_grid_h} > PX_W'(MAX_GRID)) lim_h = PX_W'(MAX_GRID);
        else lim_h = {5'b0, r_grid_h};
    end

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            bx = (k < 4 || r_r2) ? r_cur_x : r_prev_x;
            by = (k < 4 || !r_r2) ? r_cur_y : r_prev_y;
            px[k] = ((k % 2) == 1) ? PX_W'(r_cx) - PX_W'(bx) : PX_W'(r_cx) + PX_W'(bx);
            py[k] = ((k / 2) % 2 == 1) ? PX_W'(r_cy) - PX_W'(by) : PX_W'(r_cy) + PX_W'(by);
            mask[k] = (k < 4 || diag) && px[k] >= 0 && px[k] < lim_w
                      && py[k] >= 0 && py[k] < lim_h;
        end
    end

    always_comb begin
        pick = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (r_mask[k]) pick = 3'(k);
        end
    end

    assign rest = r_mask & (r_mask - 8'd1);

    always_comb begin
        cur_x_n = r_cur_x;
        cur_y_n = r_cur_y;
        incx_n  = r_incx;
        incy_n  = r_incy;
        dec_n   = r_dec;
        if (!r_r2) begin
            cur_x_n = r_cur_x + 15'sd1;
            incx_n  = r_incx + 40'($signed({1'b0, r_sq_b, 1'b0}));
            if (r_dec < 0) begin
                dec_n = r_dec + 64'(incx_n) + 64'($signed({1'b0, r_sq_b}));
            end else begin
                cur_y_n = r_cur_y - 15'sd1;
                incy_n  = r_incy - 40'($signed({1'b0, r_sq_a, 1'b0}));
                dec_n   = r_dec + 64'(incx_n) - 64'(incy_n) + 64'($signed({1'b0, r_sq_b}));
            end
        end else begin
            cur_y_n = r_cur_y - 15'sd1;
            incy_n  = r_incy - 40'($signed({1'b0, r_sq_a, 1'b0}));
            if (r_dec > 0) begin
                dec_n = r_dec + 64'($signed({1'b0, r_sq_a})) - 64'(incy_n);
            end else begin
                cur_x_n = r_cur_x + 15'sd1;
                incx_n  = r_incx + 40'($signed({1'b0, r_sq_b, 1'b0}));
                dec_n   = r_dec + 64'(incx_n) - 64'(incy_n) + 64'($signed({1'b0, r_sq_a}));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w  <= 13'd256;
            r_grid_h  <= 13'd256;
            r_cx      <= '0;
            r_cy      <= '0;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_incx    <= '0;
            r_incy    <= '0;
            r_dec     <= '0;
            r_sq_a    <= '0;
            r_sq_b    <= '0;
            r_r2      <= 1'b0;
            r_running <= 1'b0;
            r_fin     <= 1'b0;
            r_mask    <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_GRID_W) r_grid_w <= i_cfg_data;
                else r_grid_h <= i_cfg_data;
            end
            if (i_cmd.load_start) begin
                r_cx      <= i_center_x;
                r_cy      <= i_center_y;
                r_cur_x   <= '0;
                r_cur_y   <= 15'(i_semi_axis_y);
                r_prev_x  <= '0;
                r_prev_y  <= 15'(i_semi_axis_y);
                r_incx    <= '0;
                r_r2      <= 1'b0;
                r_running <= 1'b1;
            end
            if (mul_done) begin
                case (i_cmd.sel)
                    SEL_AA:  r_sq_a <= mul_prod[23:0];
                    SEL_BB:  r_sq_b <= mul_prod[23:0];
                    default: ;
                endcase
            end
            if (i_cmd.init) begin
                r_incy <= 40'({r_t1, 1'b0});
                r_dec  <= $signed(64'(r_sq_b)) - $signed(64'(r_t1))
                          + $signed(64'(r_sq_a >> 2));
            end
            if (i_cmd.trans) begin
                r_dec <= $signed(64'(r_t1 >> 2)) + $signed(64'(r_t2)) - $signed(64'(r_t3));
                r_r2  <= 1'b1;
            end
            if (i_cmd.load_pts) begin
                r_mask <= mask;
                r_fin  <= r_r2 && (r_cur_y < 15'sd1);
            end
            if (i_cmd.load_mark) begin
                r_mask <= '0;
                r_fin  <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_mask <= rest;
            end
            if (i_cmd.update) begin
                r_prev_x  <= r_cur_x;
                r_prev_y  <= r_cur_y;
                r_cur_x   <= cur_x_n;
                r_cur_y   <= cur_y_n;
                r_incx    <= incx_n;
                r_incy    <= incy_n;
                r_dec     <= dec_n;
                r_running <= r_running && !r_fin;
            end
            if (i_cmd.emit) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_done) begin
            case (i_cmd.sel)
                SEL_AB, SEL_XX, SEL_BX: r_t1 <= mul_prod;
                SEL_YY, SEL_AY:         r_t2 <= mul_prod;
                SEL_AB2:                r_t3 <= mul_prod;
                default: ;
            endcase
        end
        if (i_cmd.emit) begin
            r_pv   <= (r_mask != 8'd0);
            r_px   <= (r_mask != 8'd0) ? px[pick][11:0] : 12'd0;
            r_py   <= (r_mask != 8'd0) ? py[pick][11:0] : 12'd0;
            r_last <= (rest == 8'd0);
            r_ofin <= r_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_start) begin
            r_a <= i_semi_axis_x;
            r_b <= i_semi_axis_y;
        end
    end

    assign o_sts.mul_done   = mul_done;
    assign o_sts.need_trans = !r_r2 && !(r_incx < r_incy);
    assign o_sts.running    = r_running;
    assign o_sts.out_free   = !r_ov || i_out_ready;
    assign o_sts.emit_last  = (rest == 8'd0);

    assign o_out_valid   = r_ov;
    assign o_point_x     = r_px;
    assign o_point_y     = r_py;
    assign o_point_valid = r_pv;
    assign o_last_of_run = r_last;
    assign o_finished    = r_ofin;

`ifndef ASSERT_OFF
    a_fin_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update && r_fin |=> !r_running)
        else $error("running still set after final iteration");
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit && r_mask == 8'd0 |=> !o_point_valid && o_last_of_run)
        else $error("empty iteration did not give a closing marker");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_ov || i_out_ready)
        else $error("result overwritten before transfer");
`endif

endmodule

// ----- hdl/mel_ctrl.sv -----
`timescale 1ns / 1ps
module mel_ctrl
    import mel_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_operation,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MULGO = 4'd1;
    localparam logic [3:0] S_MULWT = 4'd2;
    localparam logic [3:0] S_INIT  = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_TRANS = 4'd5;
    localparam logic [3:0] S_LOAD  = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;
    localparam logic [3:0] S_UPD   = 4'd8;

    logic [3:0] r_state, n_state;
    logic [2:0] r_sel, n_sel;
    logic       r_mark, n_mark;

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        n_mark     = r_mark;
        o_cmd      = '0;
        o_cmd.sel  = r_sel;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_operation == OP_START) begin
                        o_cmd.load_start = 1'b1;
                        n_sel   = SEL_AA;
                        n_state = S_MULGO;
                    end else if (i_sts.running) begin
                        n_state = S_CHECK;
                    end else begin
                        o_cmd.load_mark = 1'b1;
                        n_mark  = 1'b1;
                        n_state = S_EMIT;
                    end
                end
            end
            S_MULGO: begin
                o_cmd.mul_start = 1'b1;
                n_state = S_MULWT;
            end
            S_MULWT: begin
                if (i_sts.mul_done) begin
                    if (r_sel == SEL_AB) n_state = S_INIT;
                    else if (r_sel == SEL_AB2) n_state = S_TRANS;
                    else begin
                        n_sel   = r_sel + 3'd1;
                        n_state = S_MULGO;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.need_trans) begin
                    n_sel   = SEL_XX;
                    n_state = S_MULGO;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_TRANS: begin
                o_cmd.trans = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_pts = 1'b1;
                n_mark  = 1'b0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.emit_last) n_state = r_mark ? S_IDLE : S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= SEL_AA;
            r_mark  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_mark  <= n_mark;
        end
    end

`ifndef ASSERT_OFF
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.mul_done |-> r_state == S_MULWT)
        else $error("multiplier finished outside wait state");
    a_upd_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPD |=> r_state == S_IDLE)
        else $error("update not followed by idle");
    a_mark_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && r_mark |=> r_state != S_UPD)
        else $error("idle marker changed iteration state");
`endif

endmodule

// ----- hdl/midpoint_ellipse_boundary_points_top.sv -----
`timescale 1ns / 1ps
// Sequence: a step item goes through check, point load, one emit per result and an update.
// A start item adds 3 serial multiplies and a setup step ahead of that sequence.
// Entering region 2 adds 5 serial multiplies and a transition step, once per ellipse.
// Throughput: one item at a time; up to 8 results, one per cycle while the output is ready.
// Reset: synchronous active-low; grid registers go to 256, block idle, nothing running.
module midpoint_ellipse_boundary_points_top
    import mel_pkg::*;
#(
    parameter int MAX_GRID = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mel_in_if.sink      i_in,
    mel_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [12:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    mel_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_operation (i_in.operation),
        .o_in_ready  (i_in.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mel_dp #(.MAX_GRID(MAX_GRID)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_center_x    (i_in.center_x),
        .i_center_y    (i_in.center_y),
        .i_semi_axis_x (i_in.semi_axis_x),
        .i_semi_axis_y (i_in.semi_axis_y),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_point_x     (o_out.point_x),
        .o_point_y     (o_out.point_y),
        .o_point_valid (o_out.point_valid),
        .o_last_of_run (o_out.last_of_run),
        .o_finished    (o_out.finished)
    );

endmodule
